### hw/rtl/mml_pkg.sv
// shared types and codes for the memory map line parser and lookup
package mml_pkg;

	// operation codes on the input channel
	localparam logic [1:0] OP_TEXT   = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_NO_DASH    = 3'd1;
	localparam logic [2:0] ST_NO_SP_END  = 3'd2;
	localparam logic [2:0] ST_BAD_FLAGS  = 3'd3;
	localparam logic [2:0] ST_NO_SP_FLAG = 3'd4;
	localparam logic [2:0] ST_NO_SP_OFFS = 3'd5;
	localparam logic [2:0] ST_FULL       = 3'd6;

	// one stored table entry
	typedef struct packed {
		logic [63:0] rng_start;
		logic [63:0] rng_end;
		logic [3:0]  flags;
		logic [63:0] offset;
	} tbl_entry_t;

	// what the parser reports for the byte it is looking at
	typedef struct packed {
		logic        emit;
		logic        finish;
		logic [2:0]  status;
		tbl_entry_t  rec;
	} parse_res_t;

endpackage

### hw/rtl/mml_ram.sv
// generic single write port ram with registered read
module mml_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/mml_cmp.sv
// inclusive range compare shared by every step of a lookup
module mml_cmp (
	input  logic [63:0] addr,
	input  logic [63:0] rng_start,
	input  logic [63:0] rng_end,
	output logic        hit
);

	assign hit = (rng_start <= addr) && (addr <= rng_end);

endmodule

### hw/rtl/mml_parse.sv
// line parser: hex fields, flag characters and separators of one listing line
module mml_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                clear,
	input  logic [7:0]          text_byte,
	output mml_pkg::parse_res_t res
);
	import mml_pkg::*;

	localparam logic [2:0] PH_START  = 3'd0;
	localparam logic [2:0] PH_END    = 3'd1;
	localparam logic [2:0] PH_FLAGS  = 3'd2;
	localparam logic [2:0] PH_AFTFL  = 3'd3;
	localparam logic [2:0] PH_OFFSET = 3'd4;
	localparam logic [2:0] PH_DEVICE = 3'd5;
	localparam logic [2:0] PH_INODE  = 3'd6;
	localparam logic [2:0] PH_NAME   = 3'd7;

	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_W     = 8'h77;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_P     = 8'h70;

	logic [2:0]  phase_q, phase_n;
	logic [1:0]  pos_q, pos_n;
	logic [63:0] acc_q, acc_n;
	logic [63:0] hstart_q, hstart_n;
	logic [63:0] hend_q, hend_n;
	logic [3:0]  hflags_q, hflags_n;
	logic        stopped_q, stopped_n;

	logic        dig_ok;
	logic [3:0]  dig_val;
	logic [7:0]  set_ch;
	logic [7:0]  clr_ch;
	logic        fail;
	logic [2:0]  fail_st;
	logic        fin;

	always_comb begin
		dig_ok  = 1'b0;
		dig_val = text_byte[3:0];
		if (text_byte >= 8'h30 && text_byte <= 8'h39) begin
			dig_ok = 1'b1;
		end else if (text_byte >= 8'h61 && text_byte <= 8'h66) begin
			dig_ok  = 1'b1;
			// low nibble of 'a' is 1, so add 9 to land on 10
			dig_val = text_byte[3:0] + 4'd9;
		end
	end

	always_comb begin
		unique case (pos_q)
			2'd0: begin set_ch = CH_R; clr_ch = CH_DASH; end
			2'd1: begin set_ch = CH_W; clr_ch = CH_DASH; end
			2'd2: begin set_ch = CH_X; clr_ch = CH_DASH; end
			default: begin set_ch = CH_S; clr_ch = CH_P; end
		endcase
	end

	always_comb begin
		phase_n   = phase_q;
		pos_n     = pos_q;
		acc_n     = acc_q;
		hstart_n  = hstart_q;
		hend_n    = hend_q;
		hflags_n  = hflags_q;
		stopped_n = stopped_q;
		fail      = 1'b0;
		fail_st   = ST_OK;
		fin       = 1'b0;
		res       = '0;

		if (!stopped_q) begin
			unique case (phase_q)
				PH_START, PH_END, PH_OFFSET: begin
					if (dig_ok) begin
						acc_n = {acc_q[59:0], dig_val};
					end else if (phase_q == PH_START) begin
						if (text_byte != CH_DASH) begin
							fail    = 1'b1;
							fail_st = ST_NO_DASH;
						end else begin
							hstart_n = acc_q;
							acc_n    = '0;
							phase_n  = PH_END;
						end
					end else if (phase_q == PH_END) begin
						if (text_byte != CH_SPACE) begin
							fail    = 1'b1;
							fail_st = ST_NO_SP_END;
						end else begin
							hend_n   = acc_q;
							acc_n    = '0;
							hflags_n = '0;
							pos_n    = '0;
							phase_n  = PH_FLAGS;
						end
					end else begin
						if (text_byte != CH_SPACE) begin
							fail    = 1'b1;
							fail_st = ST_NO_SP_OFFS;
						end else begin
							phase_n = PH_DEVICE;
						end
					end
				end
				PH_FLAGS: begin
					if (text_byte == set_ch) begin
						hflags_n = hflags_q | (4'd1 << pos_q);
					end else if (text_byte != clr_ch) begin
						fail    = 1'b1;
						fail_st = ST_BAD_FLAGS;
					end
					if (pos_q == 2'd3) begin
						phase_n = PH_AFTFL;
					end
					pos_n = pos_q + 2'd1;
				end
				PH_AFTFL: begin
					if (text_byte != CH_SPACE) begin
						fail    = 1'b1;
						fail_st = ST_NO_SP_FLAG;
					end else begin
						phase_n = PH_OFFSET;
					end
				end
				PH_DEVICE, PH_INODE: begin
					if (text_byte == CH_NL) begin
						fin = 1'b1;
					end else if (text_byte == CH_SPACE) begin
						phase_n = (phase_q == PH_DEVICE) ? PH_INODE : PH_NAME;
					end
				end
				default: begin
					if (text_byte == CH_NL) begin
						fin = 1'b1;
					end
				end
			endcase
		end

		if (fail || fin) begin
			phase_n  = PH_START;
			pos_n    = '0;
			acc_n    = '0;
			hstart_n = '0;
			hend_n   = '0;
			hflags_n = '0;
		end
		if (fail) begin
			stopped_n  = 1'b1;
			res.emit   = 1'b1;
			res.status = fail_st;
		end
		if (fin) begin
			res.emit          = 1'b1;
			res.finish        = 1'b1;
			res.rec.rng_start = hstart_q;
			res.rec.rng_end   = hend_q;
			res.rec.flags     = hflags_q;
			res.rec.offset    = acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			pos_q     <= '0;
			acc_q     <= '0;
			hstart_q  <= '0;
			hend_q    <= '0;
			hflags_q  <= '0;
			stopped_q <= 1'b0;
		end else if (clear) begin
			phase_q   <= PH_START;
			pos_q     <= '0;
			acc_q     <= '0;
			hstart_q  <= '0;
			hend_q    <= '0;
			hflags_q  <= '0;
			stopped_q <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_n;
			pos_q     <= pos_n;
			acc_q     <= acc_n;
			hstart_q  <= hstart_n;
			hend_q    <= hend_n;
			hflags_q  <= hflags_n;
			stopped_q <= stopped_n;
		end
	end

endmodule

### hw/rtl/memory_map_line_parser_and_lookup.sv
// top level: memory map line parser with a table of ranges and address lookup
//
// input channel (in_valid/in_ready) carries one beat per op: a text byte of the
// listing, an address lookup, or a table clear. output channel (out_valid/
// out_ready) carries parsed line records and lookup answers.
// in_ready is high only while the sequencer is idle; one beat is worked on at
// a time.
// a text byte moves the sequencer from idle to the text state and back; its
// record, if any, is loaded into the output register from the text state,
// which holds while a stalled result still waits. a lookup walks the table
// through the single compare unit, one entry at a time (table ram read, then
// compare): it ends at the first hit, or with a miss once the walk passes the
// last stored entry. clear and unused ops finish in the idle state.
// results sit in an output register; a new beat is accepted while a result
// waits, and the sequencer holds only when it must load a second result and
// the receiver still stalls.
// reset empties the table (entry count to zero, no ram clearing pass), restarts
// the line parser and drops any pending result.
module memory_map_line_parser_and_lookup #(
	parameter int ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  text_byte,
	input  logic [63:0] lookup_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [2:0]  status,
	output logic        hit,
	output logic [3:0]  entry_index,
	output logic [63:0] range_start,
	output logic [63:0] range_end,
	output logic [3:0]  access_bits,
	output logic [63:0] file_offset
);
	import mml_pkg::*;

	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int TBL_W = $bits(tbl_entry_t);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_TEXT   = 2'd1;
	localparam logic [1:0] S_LK_RD  = 2'd2;
	localparam logic [1:0] S_LK_CMP = 2'd3;

	logic [1:0]       st_q;
	logic [7:0]       byte_q;
	logic [63:0]      addr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] lk_idx_q;

	logic             accept;
	logic             slot_free;
	logic             full;
	logic             step;
	logic             clear;
	parse_res_t       pres;

	logic             ram_we;
	logic             ram_re;
	logic [TBL_W-1:0] ram_rdata;
	tbl_entry_t       rd_ent;
	logic             cmp_hit;

	logic             emit_req;
	logic             emit_kind;
	logic [2:0]       emit_status;
	logic             emit_hit;
	logic [CNT_W-1:0] emit_idx;
	tbl_entry_t       emit_rec;
	logic             out_load;
	logic [CNT_W+3:0] idx_ext;

	logic             out_valid_q;
	logic             kind_q;
	logic [2:0]       status_q;
	logic             hit_q;
	logic [3:0]       idx_q;
	tbl_entry_t       rec_q;

	assign in_ready  = (st_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign full      = (cnt_q >= CNT_W'(ENTRIES));
	assign clear     = accept && (op == OP_CLEAR);
	assign step      = (st_q == S_TEXT) && (!pres.emit || slot_free);
	assign rd_ent    = tbl_entry_t'(ram_rdata);

	mml_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.clear     (clear),
		.text_byte (byte_q),
		.res       (pres)
	);

	mml_ram #(
		.WIDTH (TBL_W),
		.DEPTH (ENTRIES),
		.AW    (IDX_W)
	) u_tbl (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (pres.rec),
		.re    (ram_re),
		.raddr (lk_idx_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	mml_cmp u_cmp (
		.addr      (addr_q),
		.rng_start (rd_ent.rng_start),
		.rng_end   (rd_ent.rng_end),
		.hit       (cmp_hit)
	);

	always_comb begin
		emit_req    = 1'b0;
		emit_kind   = 1'b0;
		emit_status = ST_OK;
		emit_hit    = 1'b0;
		emit_idx    = '0;
		emit_rec    = '0;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		unique case (st_q)
			S_TEXT: begin
				if (pres.emit) begin
					emit_req    = 1'b1;
					emit_status = pres.status;
					if (pres.finish) begin
						emit_rec = pres.rec;
						if (full) begin
							emit_status = ST_FULL;
						end else begin
							emit_idx = cnt_q;
							ram_we   = slot_free;
						end
					end
				end
			end
			S_LK_RD: begin
				if (lk_idx_q == cnt_q) begin
					// walked past the last stored entry: miss
					emit_req  = 1'b1;
					emit_kind = 1'b1;
				end else begin
					ram_re = 1'b1;
				end
			end
			S_LK_CMP: begin
				if (cmp_hit) begin
					emit_req  = 1'b1;
					emit_kind = 1'b1;
					emit_hit  = 1'b1;
					emit_idx  = lk_idx_q;
					emit_rec  = rd_ent;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_load = emit_req && slot_free;
	assign idx_ext  = {4'd0, emit_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			cnt_q    <= '0;
			lk_idx_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						unique case (op)
							OP_TEXT:   st_q <= S_TEXT;
							OP_LOOKUP: begin
								lk_idx_q <= '0;
								st_q     <= S_LK_RD;
							end
							OP_CLEAR:  cnt_q <= '0;
							default: begin
							end
						endcase
					end
				end
				S_TEXT: begin
					if (step) begin
						st_q <= S_IDLE;
					end
					if (ram_we) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_LK_RD: begin
					if (ram_re) begin
						st_q <= S_LK_CMP;
					end else if (slot_free) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					if (!cmp_hit) begin
						lk_idx_q <= lk_idx_q + CNT_W'(1);
						st_q     <= S_LK_RD;
					end else if (slot_free) begin
						st_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= text_byte;
			addr_q <= lookup_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q   <= emit_kind;
			status_q <= emit_status;
			hit_q    <= emit_hit;
			idx_q    <= idx_ext[3:0];
			rec_q    <= emit_rec;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign status      = status_q;
	assign hit         = hit_q;
	assign entry_index = idx_q;
	assign range_start = rec_q.rng_start;
	assign range_end   = rec_q.rng_end;
	assign access_bits = rec_q.flags;
	assign file_offset = rec_q.offset;

endmodule

### hw/rtl/mml_checker.sv
// port checker for the memory map parser, bound to the top level
module mml_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        kind,
	input logic [2:0]  status,
	input logic        hit,
	input logic [3:0]  entry_index,
	input logic [63:0] range_start,
	input logic [63:0] range_end,
	input logic [3:0]  access_bits,
	input logic [63:0] file_offset
);
	import mml_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(range_start) && $stable(range_end)
			&& $stable(file_offset) && $stable(status) && $stable(entry_index))
		else $error("result beat changed while stalled");

	a_lookup_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> status == ST_OK)
		else $error("lookup answer with nonzero status");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind && !hit |-> entry_index == 4'd0 && range_start == 64'd0
			&& range_end == 64'd0 && access_bits == 4'd0 && file_offset == 64'd0)
		else $error("lookup miss carries entry data");

	// a found range contains the address, so it cannot be empty
	a_hit_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind && hit |-> range_start <= range_end)
		else $error("lookup hit on an inverted range");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind && status != ST_OK && status != ST_FULL
			|-> !hit && range_start == 64'd0 && range_end == 64'd0 && entry_index == 4'd0)
		else $error("parse error record carries data");

endmodule

bind memory_map_line_parser_and_lookup mml_checker u_mml_checker (.*);

### test/tb_memory_map_line_parser_and_lookup.sv
`timescale 1ns / 1ps
// self-checking testbench for the memory map line parser and lookup block
module tb_memory_map_line_parser_and_lookup;
	import mml_pkg::*;

	localparam int TABLE_SLOTS = 16;
	localparam int RANDOM_ITEMS = 620;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 80;
	localparam int HOLD_AFTER_BEATS = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_PRINTS = 50;

	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;
	localparam logic [1:0] OP_SPARE = 2'd3;

	localparam logic [7:0] CH_NL = 8'h0a;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_DASH = 8'h2d;
	localparam logic [7:0] CH_PRIVATE = 8'h70;
	localparam logic [7:0] CH_SHARED = 8'h73;

	typedef enum logic [2:0] {
		SC_START, SC_END, SC_FLAGS, SC_FLAG_GAP, SC_OFFSET, SC_DEVICE, SC_INODE, SC_NAME
	} scan_e;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  ch;
		logic [63:0] addr;
	} beat_t;

	typedef struct packed {
		logic        kind;
		logic [2:0]  status;
		logic        hit;
		logic [3:0]  slot;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [3:0]  access;
		logic [63:0] offs;
	} map_answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  op = OP_TEXT;
	logic [7:0]  text_byte = 8'd0;
	logic [63:0] lookup_address = 64'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        kind;
	logic [2:0]  status;
	logic        hit;
	logic [3:0]  entry_index;
	logic [63:0] range_start;
	logic [63:0] range_end;
	logic [3:0]  access_bits;
	logic [63:0] file_offset;

	memory_map_line_parser_and_lookup #(.ENTRIES(TABLE_SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.text_byte(text_byte),
		.lookup_address(lookup_address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.status(status),
		.hit(hit),
		.entry_index(entry_index),
		.range_start(range_start),
		.range_end(range_end),
		.access_bits(access_bits),
		.file_offset(file_offset)
	);

	// line parser and range table as the block should hold them
	scan_e       scan = SC_START;
	logic [1:0]  flag_pos = 2'd0;
	logic [63:0] hex_acc = 64'd0;
	logic [63:0] line_start = 64'd0;
	logic [63:0] line_end = 64'd0;
	logic [3:0]  line_flags = 4'd0;
	bit          parse_stopped = 1'b0;
	int          map_count = 0;
	logic [63:0] map_start [TABLE_SLOTS];
	logic [63:0] map_end [TABLE_SLOTS];
	logic [3:0]  map_access [TABLE_SLOTS];
	logic [63:0] map_offset [TABLE_SLOTS];

	map_answer_t expected_answers [$];
	beat_t       pending [$];

	// stimulus side bookkeeping
	logic [63:0] gen_lo [$];
	logic [63:0] gen_hi [$];
	int          gen_count = 0;
	int          random_goal = 0;

	int          cycle_count = 0;
	int          mismatches = 0;
	int          beats_accepted = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	int          tx_gap = 0;
	int          rx_wait = 0;
	beat_t       current_beat;

	wire rx_hold = hold_left != 0;
	// every fourth stretch of 128 beats runs with no idling on either side
	wire calm = ((beats_accepted / 128) % 4) == 3;

	function automatic logic [7:0] flag_char(logic [1:0] p, bit set);
		if (!set)
			return (p == 2'd3) ? CH_PRIVATE : CH_DASH;
		case (p)
			2'd0: return "r";
			2'd1: return "w";
			2'd2: return "x";
			default: return CH_SHARED;
		endcase
	endfunction

	function automatic int hex_digit(logic [7:0] c);
		if (c >= "0" && c <= "9")
			return int'(c - "0");
		if (c >= "a" && c <= "f")
			return int'(c - 8'h57);
		return -1;
	endfunction

	function automatic void restart_scan();
		scan = SC_START;
		flag_pos = 2'd0;
		hex_acc = 64'd0;
		line_start = 64'd0;
		line_end = 64'd0;
		line_flags = 4'd0;
	endfunction

	function automatic void line_error(logic [2:0] st);
		map_answer_t a;
		restart_scan();
		parse_stopped = 1'b1;
		a = '0;
		a.kind = KIND_RECORD;
		a.status = st;
		expected_answers.push_back(a);
	endfunction

	function automatic void close_line();
		map_answer_t a;
		a.kind = KIND_RECORD;
		a.hit = 1'b0;
		a.lo = line_start;
		a.hi = line_end;
		a.access = line_flags;
		a.offs = hex_acc;
		restart_scan();
		if (map_count >= TABLE_SLOTS) begin
			a.status = ST_FULL;
			a.slot = 4'd0;
		end else begin
			a.status = ST_OK;
			a.slot = map_count[3:0];
			map_start[map_count] = a.lo;
			map_end[map_count] = a.hi;
			map_access[map_count] = a.access;
			map_offset[map_count] = a.offs;
			map_count++;
		end
		expected_answers.push_back(a);
	endfunction

	function automatic void scan_text(logic [7:0] c);
		int d;
		d = hex_digit(c);
		case (scan)
			SC_START, SC_END, SC_OFFSET: begin
				if (d >= 0) begin
					hex_acc = {hex_acc[59:0], d[3:0]};
				end else if (scan == SC_START) begin
					if (c != CH_DASH) begin
						line_error(ST_NO_DASH);
					end else begin
						line_start = hex_acc;
						hex_acc = 64'd0;
						scan = SC_END;
					end
				end else if (scan == SC_END) begin
					if (c != CH_SP) begin
						line_error(ST_NO_SP_END);
					end else begin
						line_end = hex_acc;
						hex_acc = 64'd0;
						line_flags = 4'd0;
						flag_pos = 2'd0;
						scan = SC_FLAGS;
					end
				end else if (c != CH_SP) begin
					line_error(ST_NO_SP_OFFS);
				end else begin
					scan = SC_DEVICE;
				end
			end
			SC_FLAGS: begin
				if (c != flag_char(flag_pos, 1'b1) && c != flag_char(flag_pos, 1'b0)) begin
					line_error(ST_BAD_FLAGS);
				end else begin
					if (c == flag_char(flag_pos, 1'b1))
						line_flags[flag_pos] = 1'b1;
					if (flag_pos == 2'd3)
						scan = SC_FLAG_GAP;
					flag_pos = flag_pos + 2'd1;
				end
			end
			SC_FLAG_GAP: begin
				if (c != CH_SP)
					line_error(ST_NO_SP_FLAG);
				else
					scan = SC_OFFSET;
			end
			SC_DEVICE, SC_INODE: begin
				if (c == CH_NL)
					close_line();
				else if (c == CH_SP)
					scan = (scan == SC_DEVICE) ? SC_INODE : SC_NAME;
			end
			default: begin
				if (c == CH_NL)
					close_line();
			end
		endcase
	endfunction

	function automatic void find_range(logic [63:0] addr);
		map_answer_t a;
		int i;
		a = '0;
		a.kind = KIND_LOOKUP;
		a.status = ST_OK;
		for (i = 0; i < map_count; i++) begin
			if (map_start[i] <= addr && map_end[i] >= addr) begin
				a.hit = 1'b1;
				a.slot = i[3:0];
				a.lo = map_start[i];
				a.hi = map_end[i];
				a.access = map_access[i];
				a.offs = map_offset[i];
				break;
			end
		end
		expected_answers.push_back(a);
	endfunction

	function automatic void predict_beat(beat_t b);
		case (b.op)
			OP_TEXT: begin
				if (!parse_stopped)
					scan_text(b.ch);
			end
			OP_LOOKUP: find_range(b.addr);
			OP_CLEAR: begin
				restart_scan();
				parse_stopped = 1'b0;
				map_count = 0;
			end
			default: ;
		endcase
	endfunction

	// ---------------- stimulus generation ----------------

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 64'd0;
			1: return '1;
			2, 3: return rand64();
			4: return {32'd0, $urandom};
			default: return 64'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic int pad_digits();
		case ($urandom_range(0, 9))
			0, 1: return $urandom_range(1, 3);
			2: return 17;
			default: return 0;
		endcase
	endfunction

	// lowercase hex text; digits above the 16th are random and shift out
	function automatic string hex_text(logic [63:0] v, int pad);
		string s;
		string digits;
		int n;
		int i;
		logic [3:0] nib;
		digits = "0123456789abcdef";
		n = 1;
		while (n < 16 && (v >> (4 * n)) != 64'd0)
			n++;
		s = "";
		for (i = n + pad - 1; i >= 0; i--) begin
			nib = (i < 16) ? v[4 * i +: 4] : 4'($urandom_range(0, 15));
			s = {s, digits.substr(nib, nib)};
		end
		return s;
	endfunction

	function automatic logic [7:0] stray_char(logic [7:0] w1, logic [7:0] w2);
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (hex_digit(c) >= 0 || c == w1 || c == w2);
		return c;
	endfunction

	function automatic logic [63:0] probe_address();
		int k;
		logic [63:0] lo;
		logic [63:0] span;
		if (gen_lo.size() == 0 || $urandom_range(0, 3) == 0)
			return $urandom_range(0, 1) ? rand64() : 64'($urandom_range(0, 65535));
		k = $urandom_range(0, gen_lo.size() - 1);
		lo = gen_lo[k];
		span = gen_hi[k] - lo;
		case ($urandom_range(0, 4))
			0: return lo;
			1: return gen_hi[k];
			2: return lo - 64'd1;
			3: return gen_hi[k] + 64'd1;
			default: return lo + ((span == '1) ? rand64() : rand64() % (span + 64'd1));
		endcase
	endfunction

	function automatic void add_beat(logic [1:0] o, logic [7:0] c, logic [63:0] a);
		pending.push_back(beat_t'{o, c, a});
		if (o != OP_SPARE)
			gen_count++;
	endfunction

	function automatic void add_lookup(logic [63:0] a);
		add_beat(OP_LOOKUP, 8'($urandom_range(0, 255)), a);
	endfunction

	function automatic void add_clear();
		add_beat(OP_CLEAR, 8'($urandom_range(0, 255)), rand64());
		gen_lo.delete();
		gen_hi.delete();
	endfunction

	// a text byte, now and then preceded by a lookup in the middle of the line
	function automatic void add_char(logic [7:0] c, bit interleave);
		if (interleave && $urandom_range(0, 39) == 0)
			add_lookup(probe_address());
		add_beat(OP_TEXT, c, rand64());
	endfunction

	function automatic void add_text(string s, bit interleave);
		int i;
		for (i = 0; i < s.len(); i++)
			add_char(s[i], interleave);
	endfunction

	function automatic void add_flags(int upto, bit interleave);
		int p;
		for (p = 0; p < upto; p++)
			add_char(flag_char(p[1:0], 1'($urandom_range(0, 1))), interleave);
	endfunction

	function automatic void add_tail(bit interleave);
		string dev;
		string inode;
		int n;
		logic [7:0] c;
		dev = $sformatf("%02h:%02h", $urandom_range(0, 255), $urandom_range(0, 255));
		inode = $sformatf("%0d", $urandom_range(0, 999999));
		add_text(" ", interleave);
		case ($urandom_range(0, 4))
			0: ;
			1: add_text(dev, interleave);
			2: add_text({dev, " ", inode}, interleave);
			default: begin
				add_text({dev, " ", inode, " "}, interleave);
				n = $urandom_range(0, 8);
				repeat (n) begin
					do
						c = 8'($urandom_range(0, 255));
					while (c == CH_NL);
					add_char(c, interleave);
				end
			end
		endcase
		add_char(CH_NL, interleave);
	endfunction

	function automatic void add_line(bit interleave, bit brief);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] offs;
		lo = brief ? 64'($urandom_range(0, 255)) : pick_value();
		if (!brief && $urandom_range(0, 3) == 0)
			hi = pick_value();
		else
			hi = lo + 64'($urandom_range(0, brief ? 255 : 4095));
		offs = brief ? 64'($urandom_range(0, 255)) : pick_value();
		add_text({hex_text(lo, brief ? 0 : pad_digits()), "-",
			hex_text(hi, brief ? 0 : pad_digits()), " "}, interleave);
		add_flags(4, interleave);
		add_text({" ", hex_text(offs, brief ? 0 : pad_digits())}, interleave);
		if (brief)
			add_text(" \n", 1'b0);
		else
			add_tail(interleave);
		if (gen_lo.size() < TABLE_SLOTS) begin
			gen_lo.push_back(lo);
			gen_hi.push_back(hi);
		end
	endfunction

	// a line that goes wrong at one separator or flag, then ignored bytes, maybe a lookup, and a clear
	function automatic void add_broken_line();
		int flaw;
		int k;
		flaw = $urandom_range(1, 5);
		if (flaw == 1 && $urandom_range(0, 2) == 0) begin
			add_beat(OP_TEXT, CH_NL, rand64());
		end else begin
			add_text(hex_text(pick_value(), pad_digits()), 1'b0);
			if (flaw == 1) begin
				add_beat(OP_TEXT, stray_char(CH_DASH, CH_DASH), rand64());
			end else begin
				add_text({"-", hex_text(pick_value(), pad_digits())}, 1'b0);
				if (flaw == 2) begin
					add_beat(OP_TEXT, stray_char(CH_SP, CH_SP), rand64());
				end else if (flaw == 3) begin
					k = $urandom_range(0, 3);
					add_text(" ", 1'b0);
					add_flags(k, 1'b0);
					add_beat(OP_TEXT, stray_char(flag_char(k[1:0], 1'b1),
						flag_char(k[1:0], 1'b0)), rand64());
				end else begin
					add_text(" ", 1'b0);
					add_flags(4, 1'b0);
					if (flaw == 5)
						add_text({" ", hex_text(pick_value(), pad_digits())}, 1'b0);
					add_beat(OP_TEXT, stray_char(CH_SP, CH_SP), rand64());
				end
			end
		end
		// stopped: these bytes are dropped, lookups still answer
		repeat ($urandom_range(0, 4))
			pending.push_back(beat_t'{OP_TEXT, 8'($urandom_range(0, 255)), rand64()});
		if ($urandom_range(0, 1))
			add_lookup(probe_address());
		add_clear();
	endfunction

	function automatic void build_directed();
		add_text("\n", 1'b0);
		add_text("7", 1'b0);
		add_lookup(64'd7);
		add_clear();
		add_text("ffffffffffffffff-ffffffffffffffff rwxs ffffffffffffffff 08:01 7\n", 1'b0);
		add_text("0-0 ---p 0 \n", 1'b0);
		add_text("123456789abcdef01-2 r-xp 10 08:01\n", 1'b0);
		add_lookup('1);
		add_lookup(64'd0);
		add_lookup(64'd5);
		add_lookup(64'h23456789abcdef01);
		add_text("a0-", 1'b0);
		add_lookup(64'd0);
		add_text("af rw-s 0 \n", 1'b0);
		add_lookup(64'ha5);
		add_beat(OP_SPARE, 8'hff, '1);
		add_text("1x", 1'b0);
		add_clear();
		add_text("1-2x", 1'b0);
		add_clear();
		add_text("1-2 rwz", 1'b0);
		add_clear();
		add_text("1-2 rwxpq", 1'b0);
		add_clear();
		add_text("1-2 rwxp 3x", 1'b0);
		add_clear();
	endfunction

	function automatic void build_random();
		int pick;
		random_goal = gen_count + RANDOM_ITEMS;
		// fill the table past its last slot once
		add_clear();
		repeat (TABLE_SLOTS + 1)
			add_line(1'b0, 1'b1);
		repeat (3)
			add_lookup(probe_address());
		while (gen_count < random_goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 66) begin
				add_line(1'b1, $urandom_range(0, 3) == 0);
			end else if (pick < 71) begin
				add_broken_line();
			end else if (pick < 87) begin
				repeat ($urandom_range(1, 3))
					add_lookup(probe_address());
			end else if (pick < 90) begin
				add_clear();
			end else if (pick < 94) begin
				repeat ($urandom_range(1, 6))
					add_beat(OP_TEXT, 8'($urandom_range(0, 255)), rand64());
				add_clear();
			end else begin
				add_beat(OP_SPARE, 8'($urandom_range(0, 255)), rand64());
			end
		end
	endfunction

	// ---------------- clock, driver, monitor ----------------

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_beat(current_beat);
				beats_accepted <= beats_accepted + 1;
				tx_gap = (calm || rx_hold) ? 0 : $urandom_range(0, 5);
			end
			if (!in_valid || in_ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (pending.size() > 0) begin
					current_beat = pending.pop_front();
					op <= current_beat.op;
					text_byte <= current_beat.ch;
					lookup_address <= current_beat.addr;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// one long receiver hold-off so the block backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && beats_accepted >= HOLD_AFTER_BEATS) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	task automatic report_mismatch(string what);
		if (mismatches < MAX_PRINTS)
			$display("mismatch: %s (cycle %0d)", what, cycle_count);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h expected %h", name, got, want));
	endtask

	task automatic check_answer();
		map_answer_t want;
		if (expected_answers.size() == 0) begin
			report_mismatch("result beat with nothing expected");
		end else begin
			want = expected_answers.pop_front();
			check_field("kind", 64'(kind), 64'(want.kind));
			check_field("status", 64'(status), 64'(want.status));
			check_field("hit", 64'(hit), 64'(want.hit));
			check_field("entry_index", 64'(entry_index), 64'(want.slot));
			check_field("range_start", range_start, want.lo);
			check_field("range_end", range_end, want.hi);
			check_field("access_bits", 64'(access_bits), 64'(want.access));
			check_field("file_offset", file_offset, want.offs);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (out_valid && out_ready) begin
				check_answer();
				rx_wait = calm ? 0 : $urandom_range(0, 5);
			end
			if (rx_hold) begin
				out_ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		build_directed();
		build_random();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pending.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_answers.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
